// ===== src/track_area_approach_trigger_top_macros.svh =====
// Assertion macros shared by the checker of the approach trigger.
`ifndef TRACK_AREA_APPROACH_TRIGGER_TOP_MACROS_SVH
`define TRACK_AREA_APPROACH_TRIGGER_TOP_MACROS_SVH

// Plain clocked assertion, active during reset as well.
`define TAP_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion that is switched off while reset is high.
`define TAP_ASSERT_DIS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== src/tap_pkg.sv =====
// Shared constants and types of the track area approach trigger.
package tap_pkg;

   localparam int ID_W        = 7;
   localparam int DIM_BITS    = 12;
   localparam int AREA_W      = 2 * DIM_BITS;
   localparam int TIMEOUT_W   = 8;
   localparam int RATIO_W     = 16;
   localparam int Q_FRAC      = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int DEF_TRACKS  = 64;
   // Tracked identities are non-negative and run from 0 to 63, so no more entries are ever addressed.
   localparam int ID_SPAN     = 64;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic KIND_TICK   = 1'b0;
   localparam logic KIND_DETECT = 1'b1;

   localparam logic [TIMEOUT_W-1:0] IDLE_MAX = '1;

   localparam logic [2:0] REG_LOST_TIMEOUT = 3'd0;
   localparam logic [2:0] REG_AREA_FLOOR   = 3'd1;
   localparam logic [2:0] REG_MAX_ASPECT   = 3'd2;
   localparam logic [2:0] REG_APPROACH     = 3'd3;
   localparam logic [2:0] REG_DEPART       = 3'd4;

   localparam logic [TIMEOUT_W-1:0] RST_LOST_TIMEOUT = 8'd5;
   localparam logic [AREA_W-1:0]    RST_AREA_FLOOR   = 24'd1000;
   localparam logic [RATIO_W-1:0]   RST_MAX_ASPECT   = 16'd512;
   localparam logic [RATIO_W-1:0]   RST_APPROACH     = 16'd307;
   localparam logic [RATIO_W-1:0]   RST_DEPART       = 16'd205;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] lost_timeout_s;
      logic [AREA_W-1:0]    area_floor;
      logic [RATIO_W-1:0]   max_aspect_q8;
      logic [RATIO_W-1:0]   approach_ratio_q8;
      logic [RATIO_W-1:0]   depart_ratio_q8;
   } cfg_type;

   typedef struct packed {
      logic                    kind;
      logic signed [ID_W-1:0]  track_id;
      logic [AREA_W-1:0]       area;
      logic                    tracked;
      logic                    eligible;
   } item_type;

endpackage

// ===== src/track_area_approach_trigger_top.sv =====
// A detection passes the input and classify registers, the queue, the table read and the update
// before its result shows on the rsp_ ports. The back end reads the table, then updates it, for a
// detection, and on a tick it walks the idle table one entry a cycle.
// busy rises while four words are in flight; results cannot be held off and are never stalled.
// Reset is synchronous: it clears the pipeline, the queue and the entry valid and armed bits,
// and loads the register defaults; the area and idle tables need no clearing pass.
module track_area_approach_trigger_top
   import tap_pkg::*;
#(
   parameter int TRACKS = DEF_TRACKS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_kind,
   input  logic signed [ID_W-1:0] req_track_id,
   input  logic [DIM_BITS-1:0]    req_box_width,
   input  logic [DIM_BITS-1:0]    req_box_height,
   output logic                   rsp_strobe,
   output logic                   rsp_trigger,
   output logic signed [ID_W-1:0] rsp_track_echo,
   output logic [AREA_W-1:0]      rsp_box_area,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   cfg_type    cfg_ff;
   logic       csr_wr;
   logic [2:0] csr_index;
   logic       pop, push, not_empty;
   item_type   push_item, head;

   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite && pready;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lost_timeout_s    <= RST_LOST_TIMEOUT;
         cfg_ff.area_floor        <= RST_AREA_FLOOR;
         cfg_ff.max_aspect_q8     <= RST_MAX_ASPECT;
         cfg_ff.approach_ratio_q8 <= RST_APPROACH;
         cfg_ff.depart_ratio_q8   <= RST_DEPART;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_LOST_TIMEOUT: cfg_ff.lost_timeout_s    <= pwdata[TIMEOUT_W-1:0];
            REG_AREA_FLOOR:   cfg_ff.area_floor        <= pwdata[AREA_W-1:0];
            REG_MAX_ASPECT:   cfg_ff.max_aspect_q8     <= pwdata[RATIO_W-1:0];
            REG_APPROACH:     cfg_ff.approach_ratio_q8 <= pwdata[RATIO_W-1:0];
            REG_DEPART:       cfg_ff.depart_ratio_q8   <= pwdata[RATIO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_LOST_TIMEOUT: prdata = CSR_DATA_W'(cfg_ff.lost_timeout_s);
         REG_AREA_FLOOR:   prdata = CSR_DATA_W'(cfg_ff.area_floor);
         REG_MAX_ASPECT:   prdata = CSR_DATA_W'(cfg_ff.max_aspect_q8);
         REG_APPROACH:     prdata = CSR_DATA_W'(cfg_ff.approach_ratio_q8);
         REG_DEPART:       prdata = CSR_DATA_W'(cfg_ff.depart_ratio_q8);
         default:          prdata = '0;
      endcase
   end

   tap_front #(
      .TRACKS (TRACKS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_track_id   (req_track_id),
      .req_box_width  (req_box_width),
      .req_box_height (req_box_height),
      .pop            (pop),
      .push           (push),
      .push_item      (push_item)
   );

   tap_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   tap_back #(
      .TRACKS (TRACKS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_valid     (not_empty),
      .head           (head),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_trigger    (rsp_trigger),
      .rsp_track_echo (rsp_track_echo),
      .rsp_box_area   (rsp_box_area)
   );

endmodule

// ===== src/tap_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module tap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tap_front.sv =====
// Front end: takes words, computes area and aspect products, classifies them.
module tap_front
   import tap_pkg::*;
#(
   parameter int TRACKS = DEF_TRACKS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_kind,
   input  logic signed [ID_W-1:0] req_track_id,
   input  logic [DIM_BITS-1:0]    req_box_width,
   input  logic [DIM_BITS-1:0]    req_box_height,
   input  logic                   pop,
   output logic                   push,
   output item_type               push_item
);

   localparam int DEPTH  = (TRACKS < ID_SPAN) ? TRACKS : ID_SPAN;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int WIDE_W = RATIO_W + DIM_BITS;
   localparam int W256_W = DIM_BITS + Q_FRAC;

   logic                   accept;
   logic [CNT_W-1:0]       credit_ff, credit_in;

   logic                   a_vld_ff;
   logic                   a_kind_ff;
   logic signed [ID_W-1:0] a_id_ff;
   logic [DIM_BITS-1:0]    a_w_ff, a_h_ff;

   logic                   b_vld_ff;
   logic                   b_kind_ff;
   logic signed [ID_W-1:0] b_id_ff;
   logic [AREA_W-1:0]      b_area_ff;
   logic [DIM_BITS-1:0]    b_w_ff;
   logic [WIDE_W-1:0]      b_wide_ff;

   logic [AREA_W-1:0]      area_a;
   logic [WIDE_W-1:0]      wide_a;
   logic [W256_W-1:0]      w_x256;
   logic                   too_wide, too_small, tracked;

   // Every word in the front or the queue holds a credit, so the queue never overflows.
   assign accept    = start && !busy;
   assign busy      = (credit_ff == CNT_W'(QUEUE_DEPTH));
   assign credit_in = credit_ff + CNT_W'(accept) - CNT_W'(pop);

   assign area_a = a_w_ff * a_h_ff;
   assign wide_a = WIDE_W'(cfg.max_aspect_q8) * WIDE_W'(a_h_ff);

   assign w_x256    = {b_w_ff, {Q_FRAC{1'b0}}};
   assign too_wide  = WIDE_W'(w_x256) > b_wide_ff;
   assign too_small = b_area_ff < cfg.area_floor;
   assign tracked   = !b_id_ff[ID_W-1] && ({1'b0, b_id_ff[ID_W-2:0]} < ID_W'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         a_vld_ff  <= 1'b0;
         b_vld_ff  <= 1'b0;
      end else begin
         credit_ff <= credit_in;
         a_vld_ff  <= accept;
         b_vld_ff  <= a_vld_ff;
      end
      if (accept) begin
         a_kind_ff <= req_kind;
         a_id_ff   <= req_track_id;
         a_w_ff    <= req_box_width;
         a_h_ff    <= req_box_height;
      end
      b_kind_ff <= a_kind_ff;
      b_id_ff   <= a_id_ff;
      b_area_ff <= area_a;
      b_w_ff    <= a_w_ff;
      b_wide_ff <= wide_a;
   end

   always_comb begin
      push_item.kind     = b_kind_ff;
      push_item.track_id = b_id_ff;
      push_item.area     = b_area_ff;
      push_item.tracked  = tracked;
      push_item.eligible = !too_small && !too_wide;
   end

   assign push = b_vld_ff;

endmodule

// ===== src/tap_fifo.sv =====
// Short queue of classified words between the front and the back end.
module tap_fifo
   import tap_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     not_empty,
   output item_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      next_ptr = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

endmodule

// ===== src/tap_back.sv =====
// Back end: per-track table, ageing on ticks and the trigger decision.
module tap_back
   import tap_pkg::*;
#(
   parameter int TRACKS = DEF_TRACKS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   head_valid,
   input  item_type               head,
   output logic                   pop,
   output logic                   rsp_strobe,
   output logic                   rsp_trigger,
   output logic signed [ID_W-1:0] rsp_track_echo,
   output logic [AREA_W-1:0]      rsp_box_area
);

   localparam int DEPTH   = (TRACKS < ID_SPAN) ? TRACKS : ID_SPAN;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WALK_W  = $clog2(DEPTH + 1);
   localparam int ENTRY_W = 2 * AREA_W;
   localparam int PROD_W  = AREA_W + RATIO_W;

   typedef enum logic [1:0] {S_IDLE, S_TICK, S_MUL, S_UPD} state_type;

   state_type               state_ff, state_in;
   logic [DEPTH-1:0]        valid_ff, valid_in;
   logic [DEPTH-1:0]        armed_ff, armed_in;
   logic [WALK_W-1:0]       walk_ff;
   item_type                cur_ff;
   logic                    fwd_hit_ff;
   logic [ENTRY_W-1:0]      fwd_data_ff;

   logic                    m_armed_ff;
   logic [AREA_W-1:0]       m_trig_ff, m_max_ff;
   logic [PROD_W-1:0]       m_app_ff, m_dep_ff;

   logic                    rsp_strobe_ff, rsp_trigger_ff;
   logic signed [ID_W-1:0]  rsp_echo_ff;
   logic [AREA_W-1:0]       rsp_area_ff;

   logic [IDX_W-1:0]        head_idx, cur_idx;
   logic [ENTRY_W-1:0]      rd_data, stored, wr_data;
   logic                    wr_en;
   logic                    entry_new, armed_eff;
   logic [AREA_W-1:0]       trig_eff, max_eff;
   logic [PROD_W-1:0]       area_x256;
   logic [AREA_W-1:0]       max_raised, trig_new, max_new;
   logic                    approaching, departing, above_max, fire, disarm, armed_next;

   logic [IDX_W-1:0]        walk_idx, wb_idx, idle_wr_addr;
   logic                    walk_wb, walk_done, drop, idle_wr_en;
   logic [TIMEOUT_W-1:0]    idle_rd, idle_next, idle_wr;

   assign head_idx = head.track_id[IDX_W-1:0];
   assign cur_idx  = cur_ff.track_id[IDX_W-1:0];

   // A tick walks the idle table: entry k is read while k-1 is written back.
   assign walk_idx  = walk_ff[IDX_W-1:0];
   assign wb_idx    = IDX_W'(walk_ff - WALK_W'(1));
   assign walk_wb   = (state_ff == S_TICK) && (walk_ff != '0);
   assign walk_done = (state_ff == S_TICK) && (walk_ff == WALK_W'(DEPTH));

   assign pop = head_valid && (state_ff == S_IDLE || state_ff == S_UPD || walk_done);

   // Table read for the word at the head; the write of the word before it
   // lands on the same edge, so a matching write is forwarded.
   tap_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_area_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_idx),
      .wr_data (wr_data),
      .rd_addr (head_idx),
      .rd_data (rd_data)
   );

   tap_ram #(
      .WIDTH (TIMEOUT_W),
      .DEPTH (DEPTH)
   ) u_idle_ram (
      .clock   (clock),
      .wr_en   (idle_wr_en),
      .wr_addr (idle_wr_addr),
      .wr_data (idle_wr),
      .rd_addr (walk_idx),
      .rd_data (idle_rd)
   );

   assign idle_next    = (idle_rd == IDLE_MAX) ? IDLE_MAX : idle_rd + TIMEOUT_W'(1);
   assign drop         = idle_next > cfg.lost_timeout_s;
   assign idle_wr_en   = walk_wb ? valid_ff[wb_idx] : ((state_ff == S_UPD) && cur_ff.tracked);
   assign idle_wr_addr = walk_wb ? wb_idx : cur_idx;
   assign idle_wr      = walk_wb ? idle_next : '0;

   // An entry that is not live reads as freshly created.
   assign entry_new = !valid_ff[cur_idx];
   assign stored    = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign trig_eff  = entry_new ? '0 : stored[ENTRY_W-1:AREA_W];
   assign max_eff   = entry_new ? '0 : stored[AREA_W-1:0];
   assign armed_eff = !entry_new && armed_ff[cur_idx];

   assign area_x256   = PROD_W'({cur_ff.area, {Q_FRAC{1'b0}}});
   assign max_raised  = (cur_ff.area > m_max_ff) ? cur_ff.area : m_max_ff;
   assign approaching = area_x256 >= m_app_ff;
   assign departing   = area_x256 <= m_dep_ff;
   // Compared against the already raised maximum, so this term never fires.
   assign above_max   = cur_ff.area > max_raised;
   assign fire        = cur_ff.tracked && cur_ff.eligible
                     && (!m_armed_ff || approaching || above_max);
   assign disarm      = cur_ff.tracked && cur_ff.eligible && !fire && m_armed_ff && departing;
   assign armed_next  = fire ? 1'b1 : (disarm ? 1'b0 : m_armed_ff);
   assign trig_new    = fire ? cur_ff.area : m_trig_ff;
   assign max_new     = fire ? cur_ff.area : max_raised;

   assign wr_en   = (state_ff == S_UPD) && cur_ff.tracked;
   assign wr_data = {trig_new, max_new};

   always_comb begin
      valid_in = valid_ff;
      armed_in = armed_ff;
      unique case (state_ff)
         S_TICK: begin
            if (walk_wb && valid_ff[wb_idx] && drop) begin
               valid_in[wb_idx] = 1'b0;
            end
         end
         S_UPD: begin
            if (cur_ff.tracked) begin
               valid_in[cur_idx] = 1'b1;
               armed_in[cur_idx] = armed_next;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (pop) begin
         state_in = (head.kind == KIND_TICK) ? S_TICK : S_MUL;
      end else begin
         unique case (state_ff)
            S_TICK:  state_in = walk_done ? S_IDLE : S_TICK;
            S_MUL:   state_in = S_UPD;
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         armed_ff      <= '0;
         walk_ff       <= '0;
         fwd_hit_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         armed_ff      <= armed_in;
         if (pop) begin
            walk_ff <= '0;
         end else if (state_ff == S_TICK && !walk_done) begin
            walk_ff <= walk_ff + WALK_W'(1);
         end
         fwd_hit_ff    <= pop && wr_en && (head_idx == cur_idx);
         rsp_strobe_ff <= (state_ff == S_UPD);
      end
      fwd_data_ff <= wr_data;
      if (pop) begin
         cur_ff <= head;
      end
      if (state_ff == S_MUL) begin
         m_armed_ff <= armed_eff;
         m_trig_ff  <= trig_eff;
         m_max_ff   <= max_eff;
         m_app_ff   <= PROD_W'(trig_eff) * PROD_W'(cfg.approach_ratio_q8);
         m_dep_ff   <= PROD_W'(trig_eff) * PROD_W'(cfg.depart_ratio_q8);
      end
      if (state_ff == S_UPD) begin
         rsp_trigger_ff <= fire;
         rsp_echo_ff    <= cur_ff.track_id;
         rsp_area_ff    <= cur_ff.area;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_trigger    = rsp_trigger_ff;
   assign rsp_track_echo = rsp_echo_ff;
   assign rsp_box_area   = rsp_area_ff;

endmodule

// ===== src/tap_checker.sv =====
// Port-level checker of the approach trigger, bound to the top level.
`include "track_area_approach_trigger_top_macros.svh"

module tap_checker
   import tap_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   busy,
   input logic                   rsp_strobe,
   input logic                   rsp_trigger,
   input logic signed [ID_W-1:0] rsp_track_echo
);

   // Nothing is in flight straight after reset.
   `TAP_ASSERT(a_reset_no_result, clock, reset |=> !rsp_strobe, "result word after reset")
   `TAP_ASSERT(a_reset_not_busy, clock, reset |=> !busy, "busy after reset")

   // The back end passes through its read state S_MUL before each update, so results never come back to back.
   `TAP_ASSERT_DIS(a_result_spacing, clock, reset, rsp_strobe |=> !rsp_strobe, "results too close")

   // A box with a negative track id, which is never tracked, never raises the trigger.
   `TAP_ASSERT_DIS(a_untracked_quiet, clock, reset, rsp_strobe && rsp_track_echo[ID_W-1] |-> !rsp_trigger, "untracked trigger")

endmodule

bind track_area_approach_trigger_top tap_checker u_tap_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_trigger    (rsp_trigger),
   .rsp_track_echo (rsp_track_echo)
);
